// ===== sv/separable_gaussian_blur_stream_unit_macros.svh =====
// assertion macros for the separable blur stream unit
`ifndef SEPARABLE_GAUSSIAN_BLUR_STREAM_UNIT_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_STREAM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgb implication check failed");

// next-cycle implication, checked out of reset
`define SGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgb next-cycle check failed");

`endif

// ===== sv/sgb_pkg.sv =====
// shared types, constants and rounding for the blur stream unit
`default_nettype none
package sgb_pkg;

  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int PSUM_W     = 17;
  localparam int PROD_W     = 34;
  localparam int ACC_W      = 37;
  localparam int IW_W       = 11;
  localparam int IH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int CMP_W      = 15;
  localparam int D_W        = 3;
  localparam int NCOEF_MAX  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ROUND_BIAS = 16384;
  localparam int FRAC_SH    = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0  = 3'd2;

  localparam logic [IW_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [IH_W-1:0] HEIGHT_RST = 13'd1024;
  localparam logic [COEF_W-1:0] COEF_RST [NCOEF_MAX] =
    '{16'd16384, 16'd8192, 16'd0, 16'd0, 16'd0, 16'd0};

  typedef struct packed {
    logic           produce;
    logic           emit;
    logic           fill;
    logic [D_W-1:0] d_hi;
    logic           row_end;
    logic           frame_end;
  } sgb_vctl_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic last_run;
  } sgb_hctl_t;

  // round half up to q8.8 and clamp to 16 bits
  function automatic logic signed [PIX_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0]      t;
    logic        [ACC_W-FRAC_SH-1:0] q;
    logic        [PIX_W-1:0]      r;
    t = s + ACC_W'(ROUND_BIAS);
    q = t[ACC_W-1:FRAC_SH];
    if (q[ACC_W-FRAC_SH-1:PIX_W-1] == {(ACC_W-FRAC_SH-PIX_W+1){q[PIX_W-1]}}) begin
      r = q[PIX_W-1:0];
    end else if (q[ACC_W-FRAC_SH-1]) begin
      r = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(PIX_W-1){1'b1}}};
    end
    return $signed(r);
  endfunction

endpackage
`default_nettype wire

// ===== sv/sgb_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none
module sgb_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/sgb_fir.sv =====
// symmetric tap multiply and accumulate, two register stages
`default_nettype none
module sgb_fir #(
  parameter int TAPS = 2
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [sgb_pkg::PSUM_W-1:0]      psum [TAPS],
  input  logic        [sgb_pkg::COEF_W-1:0]      coef [TAPS],
  output logic signed [sgb_pkg::PIX_W-1:0]       res_r
);

  logic signed [sgb_pkg::PROD_W-1:0] prod_r [TAPS];
  logic signed [sgb_pkg::ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_r[k] <= psum[k] * $signed({1'b0, coef[k]});
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + sgb_pkg::ACC_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= sgb_pkg::round_sat(acc);
    end
  end

endmodule
`default_nettype wire

// ===== sv/separable_gaussian_blur_stream_unit.sv =====
// Separable blur of half-width HALF_TAPS over one plane of signed q8.8 pixels in raster
// order, vertical pass then horizontal, edges replicated. Rate: one word per clock in and
// out while out_ready is high; at the end of each row the block emits up to HALF_TAPS+1
// results for that one input word and holds in_ready low until the last goes out, since the
// output port carries one result per cycle. The line store is one ram of MAX_WIDTH entries,
// each holding the column's last 2*HALF_TAPS rows, read once per word, written back once per
// image word with forwarding of the previous write; it needs no clearing pass after reset.
// The first HALF_TAPS rows give no output; after the last row the host sends HALF_TAPS*width
// drain words (kind 1). The user must write configuration only while idle; not enforced.
`default_nettype none
`include "separable_gaussian_blur_stream_unit_macros.svh"
module separable_gaussian_blur_stream_unit #(
  parameter int HALF_TAPS = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic signed [sgb_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sgb_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                                   out_end_of_row,
  output logic                                   out_end_of_frame,
  output logic                                   out_last_of_run,
  input  logic                                   cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int SPAN   = 2 * HALF_TAPS;
  localparam int WIN    = SPAN + 1;
  localparam int NCOEF  = HALF_TAPS + 1;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(SPAN);
  localparam int WIN_IW = $clog2(WIN);
  localparam int PW     = sgb_pkg::PIX_W;
  localparam int RAM_W  = SPAN * PW;
  localparam int CW     = sgb_pkg::CMP_W;

  // configuration
  logic [sgb_pkg::IW_W-1:0]   width_r;
  logic [sgb_pkg::IH_W-1:0]   height_r;
  logic [sgb_pkg::COEF_W-1:0] coef_r [NCOEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sgb_pkg::WIDTH_RST;
      height_r <= sgb_pkg::HEIGHT_RST;
      for (int k = 0; k < NCOEF; k++) begin
        coef_r[k] <= sgb_pkg::COEF_RST[k];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        sgb_pkg::CFG_WIDTH: begin
          width_r <= cfg_wdata[sgb_pkg::IW_W-1:0];
        end
        sgb_pkg::CFG_HEIGHT: begin
          height_r <= cfg_wdata[sgb_pkg::IH_W-1:0];
        end
        default: begin
          for (int k = 0; k < NCOEF; k++) begin
            if (cfg_index == sgb_pkg::CFG_COEF0 + sgb_pkg::CFG_IDX_W'(k)) begin
              coef_r[k] <= cfg_wdata;
            end
          end
        end
      endcase
    end
  end

  logic [AW-1:0]               w_m1;
  logic [sgb_pkg::ROW_W-1:0]   h_m1;

  always_comb begin
    if (width_r == '0) begin
      w_m1 = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_m1 = AW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = AW'(width_r - 11'd1);
    end
    h_m1 = (height_r == '0) ? '0 : height_r - 13'd1;
  end

  // handshake control
  logic adv, vadv, accept, take;
  logic job_valid_r, job_last_now;

  assign adv      = !out_valid || out_ready;
  assign vadv     = adv && (!job_valid_r || job_last_now);
  assign in_ready = vadv;
  assign accept   = in_valid && in_ready;

  // position counters
  logic [AW-1:0]             col_r, col_nxt, x;
  logic [sgb_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt, lslot_r, lslot_nxt;
  logic drain, kind_ok, last, produce, frame_done, frame_last_row;

  always_comb begin
    drain          = row_r > h_m1;
    kind_ok        = in_kind == drain;
    x              = (col_r > w_m1) ? w_m1 : col_r;
    last           = x == w_m1;
    produce        = row_r >= sgb_pkg::ROW_W'(HALF_TAPS);
    frame_done     = CW'(row_r) >= CW'(h_m1) + CW'(HALF_TAPS);
    frame_last_row = CW'(row_r) == CW'(h_m1) + CW'(HALF_TAPS);
    take           = accept && kind_ok;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    slot_nxt  = slot_r;
    lslot_nxt = lslot_r;
    if (take) begin
      if (!drain && row_r == h_m1) begin
        lslot_nxt = slot_r;
      end
      if (last) begin
        col_nxt = '0;
        if (frame_done) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + 13'd1;
          slot_nxt = (32'(slot_r) == SPAN - 1) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt = x + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      lslot_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      slot_r  <= slot_nxt;
      lslot_r <= lslot_nxt;
    end
  end

  // store slot of each vertical tap, rows above and below clamped
  logic [SLOT_W-1:0] tslot [WIN];
  logic [CW-1:0]     rp;
  logic [SLOT_W:0]   ssum;

  always_comb begin
    rp   = '0;
    ssum = '0;
    for (int o = 0; o < WIN; o++) begin
      rp   = CW'(row_r) + CW'(o);
      ssum = (SLOT_W+1)'(slot_r) + (SLOT_W+1)'((o >= SPAN) ? o - SPAN : o);
      if (rp < CW'(SPAN)) begin
        tslot[o] = '0;
      end else if (rp > CW'(h_m1) + CW'(SPAN)) begin
        tslot[o] = lslot_r;
      end else if (ssum >= (SLOT_W+1)'(SPAN)) begin
        tslot[o] = SLOT_W'(ssum - (SLOT_W+1)'(SPAN));
      end else begin
        tslot[o] = SLOT_W'(ssum);
      end
    end
  end

  sgb_pkg::sgb_vctl_t a_ctl;

  always_comb begin
    a_ctl.produce   = produce;
    a_ctl.fill      = x == '0;
    a_ctl.emit      = produce && (last || 32'(x) >= HALF_TAPS);
    a_ctl.d_hi      = (32'(x) >= HALF_TAPS) ? sgb_pkg::D_W'(HALF_TAPS) : sgb_pkg::D_W'(x);
    a_ctl.row_end   = last;
    a_ctl.frame_end = frame_last_row;
  end

  // line store
  logic             ram_we;
  logic [RAM_W-1:0] rd_data, rdw, wword;

  logic                b_valid_r, b_wr_r, b_pixtap_r;
  sgb_pkg::sgb_vctl_t  b_ctl_r;
  logic signed [PW-1:0] b_pix_r;
  logic [SLOT_W-1:0]   b_tslot_r [WIN];
  logic [SLOT_W-1:0]   b_wslot_r;
  logic [AW-1:0]       b_addr_r;

  logic             lw_valid_r;
  logic [AW-1:0]    lw_addr_r;
  logic [RAM_W-1:0] lw_data_r;

  sgb_ram #(.DATA_W(RAM_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (b_addr_r),
    .wr_data (wword),
    .rd_en   (accept),
    .rd_addr (x),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (vadv) begin
      b_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (vadv) begin
      b_wr_r     <= !drain;
      b_pixtap_r <= !drain;
      b_ctl_r    <= a_ctl;
      b_pix_r    <= in_pixel_in;
      b_tslot_r  <= tslot;
      b_wslot_r  <= slot_r;
      b_addr_r   <= x;
    end
  end

  logic signed [PW-1:0]              tap [WIN];
  logic signed [sgb_pkg::PSUM_W-1:0] b_psum [NCOEF];

  always_comb begin
    // the most recently written word may not be in the ram read yet
    rdw = (lw_valid_r && lw_addr_r == b_addr_r) ? lw_data_r : rd_data;
    for (int o = 0; o < WIN; o++) begin
      tap[o] = $signed(rdw[PW*b_tslot_r[o] +: PW]);
    end
    if (b_pixtap_r) begin
      tap[SPAN] = b_pix_r;
    end
    b_psum[0] = sgb_pkg::PSUM_W'(tap[HALF_TAPS]);
    for (int k = 1; k < NCOEF; k++) begin
      b_psum[k] = sgb_pkg::PSUM_W'(tap[HALF_TAPS-k]) + sgb_pkg::PSUM_W'(tap[HALF_TAPS+k]);
    end
    wword = rdw;
    wword[PW*b_wslot_r +: PW] = b_pix_r;
  end

  assign ram_we = b_valid_r && b_wr_r && vadv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (ram_we) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr_r <= b_addr_r;
      lw_data_r <= wword;
    end
  end

  // vertical pass
  logic                              c_valid_r, d_valid_r, e_valid_r;
  sgb_pkg::sgb_vctl_t                c_ctl_r, d_ctl_r, e_ctl_r;
  logic signed [sgb_pkg::PSUM_W-1:0] c_psum_r [NCOEF];
  logic signed [PW-1:0]              v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (vadv) begin
      c_valid_r <= b_valid_r && b_ctl_r.produce;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vadv) begin
      c_ctl_r  <= b_ctl_r;
      c_psum_r <= b_psum;
      d_ctl_r  <= c_ctl_r;
      e_ctl_r  <= d_ctl_r;
    end
  end

  sgb_fir #(.TAPS(NCOEF)) u_vfir (
    .clk   (clk),
    .en    (vadv),
    .psum  (c_psum_r),
    .coef  (coef_r),
    .res_r (v)
  );

  // horizontal window and emit job (one result mid-row, up to HALF_TAPS+1 at row end)
  logic signed [PW-1:0] win_r [WIN];
  logic signed [PW-1:0] win_nxt [WIN];
  logic signed [PW-1:0] job_win_r [WIN];
  logic [sgb_pkg::D_W-1:0] job_d_r;
  logic job_row_end_r, job_frame_end_r, emitting, load_job;

  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      win_nxt[i] = e_ctl_r.fill ? v : win_r[i+1];
    end
    win_nxt[SPAN] = v;
  end

  assign job_last_now = job_valid_r && (!job_row_end_r || job_d_r == '0);
  assign emitting     = job_valid_r && adv;
  assign load_job     = e_valid_r && e_ctl_r.emit && vadv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) begin
        win_r[i] <= '0;
      end
      job_valid_r <= 1'b0;
    end else begin
      if (e_valid_r && vadv) begin
        win_r <= win_nxt;
      end
      if (load_job) begin
        job_valid_r <= 1'b1;
      end else if (emitting && job_last_now) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      job_win_r       <= win_nxt;
      job_d_r         <= e_ctl_r.d_hi;
      job_row_end_r   <= e_ctl_r.row_end;
      job_frame_end_r <= e_ctl_r.frame_end;
    end else if (emitting) begin
      job_d_r <= job_d_r - sgb_pkg::D_W'(1);
    end
  end

  // taps for output column x-d, right edge clamped to column x
  logic signed [sgb_pkg::PSUM_W-1:0] h_psum [NCOEF];
  logic [WIN_IW-1:0] idx_n, idx_p;
  sgb_pkg::sgb_hctl_t h_ctl;

  always_comb begin
    idx_n = '0;
    idx_p = '0;
    h_psum[0] = sgb_pkg::PSUM_W'(job_win_r[WIN_IW'(SPAN) - WIN_IW'(job_d_r)]);
    for (int k = 1; k < NCOEF; k++) begin
      idx_n = WIN_IW'(SPAN) - WIN_IW'(job_d_r) - WIN_IW'(k);
      idx_p = (32'(job_d_r) >= k) ? WIN_IW'(SPAN) - WIN_IW'(job_d_r) + WIN_IW'(k)
                                  : WIN_IW'(SPAN);
      h_psum[k] = sgb_pkg::PSUM_W'(job_win_r[idx_n]) + sgb_pkg::PSUM_W'(job_win_r[idx_p]);
    end
    h_ctl.row_end   = job_row_end_r && job_d_r == '0;
    h_ctl.frame_end = job_row_end_r && job_d_r == '0 && job_frame_end_r;
    h_ctl.last_run  = job_last_now;
  end

  // horizontal pass and output register
  logic                              h1_valid_r, h2_valid_r, out_valid_r;
  sgb_pkg::sgb_hctl_t                h1_ctl_r, h2_ctl_r, out_ctl_r;
  logic signed [sgb_pkg::PSUM_W-1:0] h1_psum_r [NCOEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_valid_r  <= 1'b0;
      h2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      h1_valid_r  <= emitting;
      h2_valid_r  <= h1_valid_r;
      out_valid_r <= h2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_ctl_r  <= h_ctl;
      h1_psum_r <= h_psum;
      h2_ctl_r  <= h1_ctl_r;
      out_ctl_r <= h2_ctl_r;
    end
  end

  sgb_fir #(.TAPS(NCOEF)) u_hfir (
    .clk   (clk),
    .en    (adv),
    .psum  (h1_psum_r),
    .coef  (coef_r),
    .res_r (out_pixel_out)
  );

  assign out_valid        = out_valid_r;
  assign out_end_of_row   = out_ctl_r.row_end;
  assign out_end_of_frame = out_ctl_r.frame_end;
  assign out_last_of_run  = out_ctl_r.last_run;

  `SGB_ASSERT_IMP(a_eof_at_row_end, out_valid && out_end_of_frame, out_end_of_row)
  `SGB_ASSERT_IMP(a_row_end_closes_run, out_valid && out_end_of_row, out_last_of_run)
  `SGB_ASSERT_IMP(a_mid_row_single, job_valid_r && !job_row_end_r, job_d_r == sgb_pkg::D_W'(HALF_TAPS))
  `SGB_ASSERT_NXT(a_flush_holds_input, job_valid_r && !job_last_now && !load_job, !in_ready || job_last_now)

endmodule
`default_nettype wire
